/* design/merge_sorter_core_defines.svh */
// ----------------------------------------------------------------------------
// merge_sorter_core_defines.svh
// Assertion macros for the merge sorter; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MERGE_SORTER_CORE_DEFINES_SVH
`define MERGE_SORTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define MSORT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("merge sorter assertion failed");
`define MSORT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("merge sorter assertion failed");
`else
`define MSORT_ASSERT_SAME(lbl, ante, cons)
`define MSORT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* design/msort_pkg.sv */
// ----------------------------------------------------------------------------
// msort_pkg
// Shared constants, state type and control structs of the merge sorter.
// ----------------------------------------------------------------------------
package msort_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SPAN_W = CNT_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MERGE,
    ST_EMIT
  } state_t;

  // Memory control from the sequencer: both stores see the same read addresses
  typedef struct packed {
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic              src_scratch;
    logic              wr_value;
    logic              wr_scratch;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
  } mem_ctl_t;

  typedef struct packed {
    logic emit;
    logic emit_last;
    logic overflowed;
  } emit_t;

endpackage

/* design/merge_sorter_core.sv */
// ----------------------------------------------------------------------------
// merge_sorter_core
// Collects a set of signed words and returns it in stable ascending order.
// ----------------------------------------------------------------------------
// A set of n elements (1 to 64) is loaded one per accepted request, merged
// in ceil(log2 n) passes and returned as n results: one merge step per
// cycle, set by the single compare between the two read ports of the current
// source store. Requests are taken only while busy is low. Results come out
// as an unbroken run of out_valid pulses, via the emit state and the output
// register after the last merge step (or the request of a one-element set),
// and cannot be held off; busy drops on the cycle that shows the final
// result, so the next set may start there. Requests beyond 64 in one set are
// dropped and every result of that set carries out_overflowed.
`include "merge_sorter_core_defines.svh"

module merge_sorter_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [msort_pkg::DATA_W-1:0] in_value,
  input  logic                                in_last_in,
  output logic                                out_valid,
  output logic signed [msort_pkg::DATA_W-1:0] out_sorted_value,
  output logic                                out_last_out,
  output logic                                out_overflowed
);

  localparam int DW = msort_pkg::DATA_W;

  msort_pkg::mem_ctl_t ctl;
  msort_pkg::emit_t    emit;
  logic [DW-1:0] val_rd_a, val_rd_b, scr_rd_a, scr_rd_b;
  logic [DW-1:0] rd_a, rd_b;
  logic          out_valid_r;
  logic [DW-1:0] out_value_r;
  logic          out_last_r, out_ovf_r;

  msort_ram #(.DW(DW), .N(msort_pkg::DEPTH)) u_value_store (
    .clk  (clk),
    .we   (ctl.wr_value),
    .wa   (ctl.wr_addr),
    .wd   (ctl.wr_data),
    .ra_a (ctl.rd_addr_a),
    .ra_b (ctl.rd_addr_b),
    .rd_a (val_rd_a),
    .rd_b (val_rd_b)
  );

  msort_ram #(.DW(DW), .N(msort_pkg::DEPTH)) u_scratch_store (
    .clk  (clk),
    .we   (ctl.wr_scratch),
    .wa   (ctl.wr_addr),
    .wd   (ctl.wr_data),
    .ra_a (ctl.rd_addr_a),
    .ra_b (ctl.rd_addr_b),
    .rd_a (scr_rd_a),
    .rd_b (scr_rd_b)
  );

  assign rd_a = ctl.src_scratch ? scr_rd_a : val_rd_a;
  assign rd_b = ctl.src_scratch ? scr_rd_b : val_rd_b;

  msort_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_value   (in_value),
    .in_last_in (in_last_in),
    .rd_a       (rd_a),
    .rd_b       (rd_b),
    .busy       (busy),
    .ctl        (ctl),
    .emit       (emit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= emit.emit;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= rd_a;
    out_last_r  <= emit.emit_last;
    out_ovf_r   <= emit.overflowed;
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = $signed(out_value_r);
  assign out_last_out     = out_last_r;
  assign out_overflowed   = out_ovf_r;

  `MSORT_ASSERT_NEXT(a_gap_after_last, out_valid && out_last_out, !out_valid)
  `MSORT_ASSERT_NEXT(a_run_unbroken, out_valid && !out_last_out, out_valid)
  `MSORT_ASSERT_SAME(a_done_on_last, $fell(busy), out_valid && out_last_out)
  `MSORT_ASSERT_SAME(a_busy_mid_run, out_valid && !out_last_out, busy)

endmodule

/* design/msort_ram.sv */
// ----------------------------------------------------------------------------
// msort_ram
// One write port, two registered read ports, write-first on an address match.
// ----------------------------------------------------------------------------
module msort_ram #(
  parameter int DW = 32,
  parameter int N  = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(N)-1:0] wa,
  input  logic [DW-1:0]        wd,
  input  logic [$clog2(N)-1:0] ra_a,
  input  logic [$clog2(N)-1:0] ra_b,
  output logic [DW-1:0]        rd_a,
  output logic [DW-1:0]        rd_b
);

  logic [DW-1:0] mem [N];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    // forward the entry being written this cycle
    rd_a <= (we && (wa == ra_a)) ? wd : mem[ra_a];
    rd_b <= (we && (wa == ra_b)) ? wd : mem[ra_b];
  end

endmodule

/* design/msort_ctrl.sv */
// ----------------------------------------------------------------------------
// msort_ctrl
// Load, bottom-up merge and emit sequencer; one element per request or cycle.
// ----------------------------------------------------------------------------
module msort_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [msort_pkg::DATA_W-1:0] in_value,
  input  logic                              in_last_in,
  input  logic [msort_pkg::DATA_W-1:0]      rd_a,
  input  logic [msort_pkg::DATA_W-1:0]      rd_b,
  output logic                              busy,
  output msort_pkg::mem_ctl_t               ctl,
  output msort_pkg::emit_t                  emit
);

  localparam int CW = msort_pkg::CNT_W;
  localparam int SW = msort_pkg::SPAN_W;
  localparam int AW = msort_pkg::ADDR_W;

  msort_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic          sel_r, sel_nxt;
  logic [SW-1:0] w_r, w_nxt;
  logic [CW-1:0] a_r, a_nxt;
  logic [CW-1:0] b_r, b_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic [CW-1:0] hi_r, hi_nxt;

  logic          accept, room, store;
  logic [CW-1:0] count_acc;
  logic          take_a, seg_end, pass_end, sort_done, emit_last;
  logic [CW-1:0] k_inc, lo_next, rem, seg_mid, seg_hi;
  logic [SW-1:0] w_dbl, w_next;
  logic [SW:0]   w2_next;

  assign accept    = start && (state_r == msort_pkg::ST_IDLE);
  assign room      = (count_r != CW'(msort_pkg::DEPTH));
  assign store     = accept && room;
  assign count_acc = count_r + CW'(store);

  // stable compare: ties take the left run
  assign take_a   = (a_r < mid_r) &&
                    (!(b_r < hi_r) || ($signed(rd_a) <= $signed(rd_b)));
  assign k_inc    = k_r + CW'(1);
  assign seg_end  = (k_inc == hi_r);
  assign pass_end = (hi_r == count_r);
  assign w_dbl    = w_r << 1;
  assign sort_done = pass_end && (w_dbl >= {1'b0, count_r});
  assign lo_next  = pass_end ? '0 : hi_r;
  assign w_next   = pass_end ? w_dbl : w_r;
  assign w2_next  = {w_next, 1'b0};
  assign rem      = count_r - lo_next;
  assign seg_mid  = ({1'b0, rem} > w_next) ? CW'(lo_next + CW'(w_next)) : count_r;
  assign seg_hi   = ({2'b0, rem} > w2_next) ? CW'(lo_next + CW'(w2_next)) : count_r;
  assign emit_last = ((a_r + CW'(1)) == count_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      msort_pkg::ST_IDLE: begin
        if (accept && in_last_in) begin
          state_nxt = (count_acc == CW'(1)) ? msort_pkg::ST_EMIT : msort_pkg::ST_MERGE;
        end
      end
      msort_pkg::ST_MERGE: begin
        if (seg_end && sort_done) begin
          state_nxt = msort_pkg::ST_EMIT;
        end
      end
      msort_pkg::ST_EMIT: begin
        if (emit_last) begin
          state_nxt = msort_pkg::ST_IDLE;
        end
      end
      default: state_nxt = msort_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    sel_nxt   = sel_r;
    w_nxt     = w_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    k_nxt     = k_r;
    mid_nxt   = mid_r;
    hi_nxt    = hi_r;
    ctl.wr_value    = 1'b0;
    ctl.wr_scratch  = 1'b0;
    ctl.wr_addr     = k_r[AW-1:0];
    ctl.wr_data     = take_a ? rd_a : rd_b;
    ctl.src_scratch = sel_r;
    emit.emit       = 1'b0;
    emit.emit_last  = emit_last;
    emit.overflowed = ovf_r;
    case (state_r)
      msort_pkg::ST_IDLE: begin
        if (accept) begin
          ctl.wr_value = store;
          ctl.wr_addr  = count_r[AW-1:0];
          ctl.wr_data  = in_value;
          count_nxt    = count_acc;
          if (!room) begin
            ovf_nxt = 1'b1;
          end
          if (in_last_in) begin
            // prime the first segment of the width-one pass
            sel_nxt = 1'b0;
            w_nxt   = SW'(1);
            a_nxt   = '0;
            b_nxt   = CW'(1);
            k_nxt   = '0;
            mid_nxt = CW'(1);
            hi_nxt  = CW'(2);
          end
        end
      end
      msort_pkg::ST_MERGE: begin
        ctl.wr_value   = sel_r;
        ctl.wr_scratch = !sel_r;
        a_nxt = a_r + CW'(take_a);
        b_nxt = b_r + CW'(!take_a);
        k_nxt = k_inc;
        if (seg_end) begin
          // open the next segment, or the next pass from the other store
          a_nxt   = lo_next;
          b_nxt   = seg_mid;
          k_nxt   = lo_next;
          mid_nxt = seg_mid;
          hi_nxt  = seg_hi;
          w_nxt   = w_next;
          if (pass_end) begin
            sel_nxt = !sel_r;
          end
        end
      end
      msort_pkg::ST_EMIT: begin
        emit.emit = 1'b1;
        a_nxt     = a_r + CW'(1);
        if (emit_last) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
        end
      end
      default: begin
        a_nxt = a_r;
      end
    endcase
    ctl.rd_addr_a = a_nxt[AW-1:0];
    ctl.rd_addr_b = b_nxt[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= msort_pkg::ST_IDLE;
      count_r <= '0;
      ovf_r   <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r   <= w_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    k_r   <= k_nxt;
    mid_r <= mid_nxt;
    hi_r  <= hi_nxt;
  end

  assign busy = (state_r != msort_pkg::ST_IDLE);

endmodule

/* test/merge_sorter_core_test.sv */
// ----------------------------------------------------------------------------
// merge_sorter_core_test
// Feeds the merge sorter sets of signed words: hand-picked extremes and
// ties first, then random sets that include full and overflowing ones. Each
// result is checked against a stable ascending sort kept in the test, with
// the last marker and the dropped-request flag. The sender's gaps vary
// across the run.
// ----------------------------------------------------------------------------
module merge_sorter_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_W = msort_pkg::DATA_W;
  localparam int DEPTH  = msort_pkg::DEPTH;

  localparam int unsigned SET_ITEMS      = 330;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 100;

  localparam logic signed [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
    logic                     overflowed;
  } sorted_word_t;

  class sort_scoreboard;
    logic signed [DATA_W-1:0] set_values[$];
    bit                       set_dropped;
    sorted_word_t             expected_words[$];
    int unsigned              errors;

    // Collect one request; on the last one sort the set and queue its words
    function void note_request(logic signed [DATA_W-1:0] value, logic last);
      logic signed [DATA_W-1:0] key;
      int                       j;
      sorted_word_t             word;
      if (set_values.size() < DEPTH) begin
        set_values.push_back(value);
      end else begin
        set_dropped = 1'b1;
      end
      if (last) begin
        // Insertion sort: shift only strictly greater words, so ties keep order
        for (int i = 1; i < set_values.size(); i++) begin
          key = set_values[i];
          j   = i - 1;
          while (j >= 0 && set_values[j] > key) begin
            set_values[j+1] = set_values[j];
            j--;
          end
          set_values[j+1] = key;
        end
        foreach (set_values[k]) begin
          word.sorted_value = set_values[k];
          word.last_out     = (k == set_values.size() - 1);
          word.overflowed   = set_dropped;
          expected_words.push_back(word);
        end
        set_values.delete();
        set_dropped = 1'b0;
      end
    endfunction

    function void check_result(logic signed [DATA_W-1:0] value, logic last,
                               logic dropped);
      sorted_word_t word;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result, value %0d last %b overflowed %b",
                 $time, value, last, dropped);
        errors++;
        return;
      end
      word = expected_words.pop_front();
      if (value !== word.sorted_value) begin
        $display("%0t: out_sorted_value expected %0d, actual %0d",
                 $time, word.sorted_value, value);
        errors++;
      end
      if (last !== word.last_out) begin
        $display("%0t: out_last_out expected %b, actual %b",
                 $time, word.last_out, last);
        errors++;
      end
      if (dropped !== word.overflowed) begin
        $display("%0t: out_overflowed expected %b, actual %b",
                 $time, word.overflowed, dropped);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return expected_words.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n      = 1'b0;
  logic                     start      = 1'b0;
  logic                     busy;
  logic signed [DATA_W-1:0] in_value   = '0;
  logic                     in_last_in = 1'b0;
  logic                     out_valid;
  logic signed [DATA_W-1:0] out_sorted_value;
  logic                     out_last_out;
  logic                     out_overflowed;

  sort_scoreboard board = new();
  int unsigned    items_sent;

  merge_sorter_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_value         (in_value),
    .in_last_in       (in_last_in),
    .out_valid        (out_valid),
    .out_sorted_value (out_sorted_value),
    .out_last_out     (out_last_out),
    .out_overflowed   (out_overflowed)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) begin
        board.check_result(out_sorted_value, out_last_out, out_overflowed);
      end
      if (start && !busy) begin
        board.note_request(in_value, in_last_in);
      end
    end
  end

  function automatic int unsigned sender_idle_pct();
    if (items_sent < SET_ITEMS / 3) return 28;
    if (items_sent < 2 * SET_ITEMS / 3) return 74;
    return 0;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    // Mostly full-range words, with a share of small ones to force ties
    if ($urandom_range(9, 0) < 3) return DATA_W'(int'($urandom_range(8, 0)) - 4);
    return $urandom;
  endfunction

  task automatic send_request(input logic signed [DATA_W-1:0] value, input logic last);
    // Idle each cycle with the current probability before raising the request
    if ($urandom_range(99, 0) < sender_idle_pct()) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < sender_idle_pct());
    end
    start      <= 1'b1;
    in_value   <= value;
    in_last_in <= last;
    // Hold the request until an edge sees busy low
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic send_set(input int unsigned size);
    for (int unsigned k = 0; k < size; k++) begin
      send_request(pick_value(), k == size - 1);
    end
  endtask

  initial begin
    logic signed [DATA_W-1:0] mixed[$];
    int unsigned              pick;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    send_request(WORD_MAX, 1'b1);
    mixed = '{0, -1, 1, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX, -1, 0, 1};
    foreach (mixed[k]) send_request(mixed[k], k == mixed.size() - 1);
    send_request(WORD_MIN, 1'b1);
    mixed = '{5, 5, -5, 5};
    foreach (mixed[k]) send_request(mixed[k], k == mixed.size() - 1);

    // One full set, and one that drops requests including the last
    send_set(DEPTH);
    send_set(DEPTH + 3);
    while (items_sent < SET_ITEMS) begin
      pick = $urandom_range(99, 0);
      if (pick < 5) begin
        send_set(DEPTH);
      end else if (pick < 10) begin
        send_set($urandom_range(DEPTH + 6, DEPTH + 1));
      end else begin
        send_set($urandom_range(16, 1));
      end
    end
    start <= 1'b0;

    while (board.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("merge_sorter_core_test passed");
    end else begin
      $display("merge_sorter_core_test failed");
    end
    $finish;
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (out_valid || (start && !busy)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no request or result accepted for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("merge_sorter_core_test failed");
    $finish;
  end

endmodule
